FILE: rtl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// Shared widths, queue sizing and the job record passed from the front end
// to the edge-test back end of the point-in-polygon crossing test.
// ----------------------------------------------------------------------------
package pip_pkg;

  // coordinate width of every input coordinate field
  localparam int COORD_W = 16;
  // coordinate differences carry one more bit
  localparam int DIFF_W  = COORD_W + 1;
  // exact product of two differences
  localparam int PROD_W  = 2 * DIFF_W;
  // difference of two products (cross product)
  localparam int CROSS_W = PROD_W + 1;

  // vertices needed for a real polygon
  localparam logic [1:0] MIN_VERTICES = 2'd3;

  // job queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // one accepted vertex, classified: the edges (prev->current, closing) to test against f->p
  typedef struct packed {
    logic                       has_edge;   // prev -> current edge present
    logic                       has_close;  // current -> first closing edge
    logic                       last;       // polygon ends with this item
    logic                       too_few;    // polygon ended below three vertices
    logic signed [COORD_W-1:0]  prev_x;
    logic signed [COORD_W-1:0]  prev_y;
    logic signed [COORD_W-1:0]  cur_x;
    logic signed [COORD_W-1:0]  cur_y;
    logic signed [COORD_W-1:0]  first_x;
    logic signed [COORD_W-1:0]  first_y;
    logic signed [COORD_W-1:0]  p_x;
    logic signed [COORD_W-1:0]  p_y;
    logic signed [COORD_W-1:0]  f_x;
    logic signed [COORD_W-1:0]  f_y;
  } job_t;

endpackage

FILE: rtl/pip_ifs.sv
// ----------------------------------------------------------------------------
// pip channel interfaces
// Valid/ready channels for vertex items in and polygon results out.
// ----------------------------------------------------------------------------
interface pip_vtx_if;
  logic                               valid;
  logic                               ready;
  logic signed [pip_pkg::COORD_W-1:0] vertex_x;
  logic signed [pip_pkg::COORD_W-1:0] vertex_y;
  logic signed [pip_pkg::COORD_W-1:0] point_x;
  logic signed [pip_pkg::COORD_W-1:0] point_y;
  logic signed [pip_pkg::COORD_W-1:0] far_x;
  logic signed [pip_pkg::COORD_W-1:0] far_y;
  logic                               last_vertex;

  modport source (output valid, vertex_x, vertex_y, point_x, point_y, far_x, far_y,
                  last_vertex, input ready);
  modport sink (input valid, vertex_x, vertex_y, point_x, point_y, far_x, far_y,
                last_vertex, output ready);
endinterface

interface pip_res_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic too_few;
  logic degenerate;

  modport source (output valid, inside_res, too_few, degenerate, input ready);
  modport sink (input valid, inside_res, too_few, degenerate, output ready);
endinterface

FILE: rtl/point_in_polygon_crossing_test.sv
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_test
// Streaming ray-crossing point-in-polygon test, one vertex item per cycle when ready.
// ----------------------------------------------------------------------------
// Polygon vertices arrive one per item on vtx, each carrying the query point
// p and a far reference point f; last_vertex marks the end of a polygon. The
// block tests every edge (previous to current, and current back to first on
// the last vertex) against the segment f->p with exact integer cross products
// and counts crossings where both intersection parameters lie in [0,1). One
// result item leaves on res per polygon: inside_res for an odd crossing count,
// too_few when fewer than three vertices came in, degenerate when some edge was
// parallel to f->p (such an edge counts no crossing). Throughput is one vertex
// per cycle while vtx.ready is high, set by the edge and closing-edge test units that work
// on each item at once (six 17x17 products per edge). An accepted item is
// classified by the front end into a job on its way into a four-entry job
// queue; a product stage and a compare stage follow, and the result register
// drives res. The queue lets vertices keep flowing while a result waits on res;
// only when the queue fills does vtx.ready drop.
module point_in_polygon_crossing_test (
  input  logic      clk,
  input  logic      rst,
  pip_vtx_if.sink   vtx,
  pip_res_if.source res
);

  // front end to queue
  pip_pkg::job_t front_job;
  logic          front_valid;
  logic          front_ready;

  // queue to back end
  pip_pkg::job_t back_job;
  logic          back_valid;
  logic          back_ready;

  // vertex bookkeeping and edge classification
  pip_front u_front (
    .clk       (clk),
    .rst       (rst),
    .vtx       (vtx),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (front_ready)
  );

  // decoupling queue
  pip_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_job   (front_job),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_job    (back_job),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  // edge tests, parity and result register
  pip_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (back_job),
    .job_valid (back_valid),
    .job_ready (back_ready),
    .res       (res)
  );

endmodule

FILE: rtl/pip_front.sv
// ----------------------------------------------------------------------------
// pip_front
// Accepts vertex items, tracks first/previous vertex and vertex count, and
// turns each item into a job naming the edges the back end must test.
// ----------------------------------------------------------------------------
module pip_front (
  input  logic           clk,
  input  logic           rst,
  pip_vtx_if.sink        vtx,
  output pip_pkg::job_t  job,
  output logic           job_valid,
  input  logic           job_ready
);

  logic signed [pip_pkg::COORD_W-1:0] first_x;
  logic signed [pip_pkg::COORD_W-1:0] first_y;
  logic signed [pip_pkg::COORD_W-1:0] prev_x;
  logic signed [pip_pkg::COORD_W-1:0] prev_y;
  logic [1:0]                         count;
  logic                               accept;

  assign vtx.ready = job_ready;
  assign job_valid = vtx.valid;
  assign accept    = vtx.valid && job_ready;

  always_comb begin
    job.has_edge  = (count != 2'd0);
    job.has_close = vtx.last_vertex && (count >= 2'd2);
    job.last      = vtx.last_vertex;
    job.too_few   = vtx.last_vertex && (count < 2'd2);
    job.prev_x    = prev_x;
    job.prev_y    = prev_y;
    job.cur_x     = vtx.vertex_x;
    job.cur_y     = vtx.vertex_y;
    // a polygon of one vertex closes on itself; no edge is used then
    job.first_x   = (count == 2'd0) ? vtx.vertex_x : first_x;
    job.first_y   = (count == 2'd0) ? vtx.vertex_y : first_y;
    job.p_x       = vtx.point_x;
    job.p_y       = vtx.point_y;
    job.f_x       = vtx.far_x;
    job.f_y       = vtx.far_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (accept) begin
      if (vtx.last_vertex) begin
        count <= 2'd0;
      end else if (count < pip_pkg::MIN_VERTICES) begin
        count <= count + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (count == 2'd0) begin
        first_x <= vtx.vertex_x;
        first_y <= vtx.vertex_y;
      end
      prev_x <= vtx.vertex_x;
      prev_y <= vtx.vertex_y;
    end
  end

endmodule

FILE: rtl/pip_queue.sv
// ----------------------------------------------------------------------------
// pip_queue
// Short job queue decoupling the front end from the edge-test back end.
// ----------------------------------------------------------------------------
module pip_queue (
  input  logic           clk,
  input  logic           rst,
  input  pip_pkg::job_t  push_job,
  input  logic           push_valid,
  output logic           push_ready,
  output pip_pkg::job_t  pop_job,
  output logic           pop_valid,
  input  logic           pop_ready
);

  pip_pkg::job_t                   mem [pip_pkg::QDEPTH];
  logic [pip_pkg::QPTR_W-1:0]      wr_ptr;
  logic [pip_pkg::QPTR_W-1:0]      rd_ptr;
  logic [pip_pkg::QCNT_W-1:0]      count;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = (count != pip_pkg::QCNT_W'(pip_pkg::QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + pip_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + pip_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + pip_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - pip_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

endmodule

FILE: rtl/pip_back.sv
// ----------------------------------------------------------------------------
// pip_back
// Two-stage edge test pipeline (products, then cross-product compares),
// crossing parity accumulation and the registered result output.
// ----------------------------------------------------------------------------
module pip_back (
  input  logic           clk,
  input  logic           rst,
  input  pip_pkg::job_t  job,
  input  logic           job_valid,
  output logic           job_ready,
  pip_res_if.source      res
);

  localparam int DiffW  = pip_pkg::DIFF_W;
  localparam int ProdW  = pip_pkg::PROD_W;
  localparam int CrossW = pip_pkg::CROSS_W;

  typedef struct packed {
    logic signed [ProdW-1:0] dx_ey;
    logic signed [ProdW-1:0] dy_ex;
    logic signed [ProdW-1:0] wy_ex;
    logic signed [ProdW-1:0] wx_ey;
    logic signed [ProdW-1:0] wy_dx;
    logic signed [ProdW-1:0] wx_dy;
  } prods_t;

  typedef struct packed {
    logic has_edge;
    logic has_close;
    logic last;
    logic too_few;
  } flags_t;

  function automatic logic signed [DiffW-1:0] dif(
    input logic signed [pip_pkg::COORD_W-1:0] a,
    input logic signed [pip_pkg::COORD_W-1:0] b
  );
    dif = DiffW'(a) - DiffW'(b);
  endfunction

  function automatic logic signed [ProdW-1:0] mul(
    input logic signed [DiffW-1:0] a,
    input logic signed [DiffW-1:0] b
  );
    mul = ProdW'(a) * ProdW'(b);
  endfunction

  // products for edge a->b against segment f->p
  function automatic prods_t edge_prods(
    input logic signed [pip_pkg::COORD_W-1:0] ax,
    input logic signed [pip_pkg::COORD_W-1:0] ay,
    input logic signed [pip_pkg::COORD_W-1:0] bx,
    input logic signed [pip_pkg::COORD_W-1:0] by,
    input logic signed [pip_pkg::COORD_W-1:0] px,
    input logic signed [pip_pkg::COORD_W-1:0] py,
    input logic signed [pip_pkg::COORD_W-1:0] fx,
    input logic signed [pip_pkg::COORD_W-1:0] fy
  );
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    logic signed [DiffW-1:0] ex;
    logic signed [DiffW-1:0] ey;
    logic signed [DiffW-1:0] wx;
    logic signed [DiffW-1:0] wy;
    prods_t                  r;
    dx = dif(bx, ax);
    dy = dif(by, ay);
    ex = dif(px, fx);
    ey = dif(py, fy);
    wx = dif(ax, fx);
    wy = dif(ay, fy);
    r.dx_ey = mul(dx, ey);
    r.dy_ex = mul(dy, ex);
    r.wy_ex = mul(wy, ex);
    r.wx_ey = mul(wx, ey);
    r.wy_dx = mul(wy, dx);
    r.wx_dy = mul(wx, dy);
    return r;
  endfunction

  // 1 when t (or u) numerator lies in [0,1) of the denominator, either sign
  function automatic logic in_unit(
    input logic signed [CrossW-1:0] num,
    input logic signed [CrossW-1:0] den
  );
    if (!den[CrossW-1]) begin
      in_unit = !num[CrossW-1] && (num < den);
    end else begin
      in_unit = (num <= 0) && (num > den);
    end
  endfunction

  // {parallel, crossing}
  function automatic logic [1:0] edge_eval(input prods_t p);
    logic signed [CrossW-1:0] den;
    logic signed [CrossW-1:0] tn;
    logic signed [CrossW-1:0] un;
    logic                     par;
    den = CrossW'(p.dx_ey) - CrossW'(p.dy_ex);
    tn  = CrossW'(p.wy_ex) - CrossW'(p.wx_ey);
    un  = CrossW'(p.wy_dx) - CrossW'(p.wx_dy);
    par = (den == '0);
    return {par, !par && in_unit(tn, den) && in_unit(un, den)};
  endfunction

  logic   adv;
  logic   s1_valid;
  flags_t s1_flags;
  prods_t s1_edge;
  prods_t s1_close;
  logic   s2_valid;
  flags_t s2_flags;
  logic   s2_cross_e;
  logic   s2_par_e;
  logic   s2_cross_c;
  logic   s2_par_c;
  logic   parity;
  logic   seen;
  logic   parity_next;
  logic   seen_next;
  logic [1:0] eval_e;
  logic [1:0] eval_c;

  // whole pipeline moves when the output slot can take a value
  assign adv       = !res.valid || res.ready;
  assign job_ready = adv;

  assign eval_e = edge_eval(s1_edge);
  assign eval_c = edge_eval(s1_close);

  assign parity_next = parity ^ s2_cross_e ^ s2_cross_c;
  assign seen_next   = seen | s2_par_e | s2_par_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      parity    <= 1'b0;
      seen      <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid <= job_valid;
        s2_valid <= s1_valid;
        if (s2_valid) begin
          if (s2_flags.last) begin
            parity <= 1'b0;
            seen   <= 1'b0;
          end else begin
            parity <= parity_next;
            seen   <= seen_next;
          end
        end
        res.valid <= s2_valid && s2_flags.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_flags <= '{has_edge: job.has_edge, has_close: job.has_close,
                    last: job.last, too_few: job.too_few};
      s1_edge  <= edge_prods(job.prev_x, job.prev_y, job.cur_x, job.cur_y,
                             job.p_x, job.p_y, job.f_x, job.f_y);
      s1_close <= edge_prods(job.cur_x, job.cur_y, job.first_x, job.first_y,
                             job.p_x, job.p_y, job.f_x, job.f_y);
      s2_flags   <= s1_flags;
      s2_cross_e <= s1_flags.has_edge && eval_e[0];
      s2_par_e   <= s1_flags.has_edge && eval_e[1];
      s2_cross_c <= s1_flags.has_close && eval_c[0];
      s2_par_c   <= s1_flags.has_close && eval_c[1];
      res.inside_res <= !s2_flags.too_few && parity_next;
      res.too_few    <= s2_flags.too_few;
      res.degenerate <= !s2_flags.too_few && seen_next;
    end
  end

endmodule
